@@ src/saa_pkg.sv @@
// ----------------------------------------------------------------------------
// saa_pkg - shared types and codes for the shelf atlas allocator
// Request/result payloads, status codes and controller-to-datapath commands.
// ----------------------------------------------------------------------------
package saa_pkg;

  localparam int PAGES_DEF       = 32;
  localparam int NODES_DEF       = 4096;
  localparam int PAGE_WIDTH_DEF  = 128;
  localparam int PAGE_HEIGHT_DEF = 128;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_POOL_EMPTY = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  req_width;
    logic [7:0]  req_height;
    logic [11:0] free_handle;
  } req_t;

  typedef struct packed {
    logic [11:0] handle;
    logic [4:0]  page;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [2:0]  status;
  } res_t;

  typedef logic [5:0] op_t;

  localparam op_t OP_NOP        = 6'd0;
  localparam op_t OP_LATCH      = 6'd1;
  localparam op_t OP_SWEEP_INIT = 6'd2;
  localparam op_t OP_SWEEP      = 6'd3;
  localparam op_t OP_SET_STAT   = 6'd4;
  localparam op_t OP_PUSH       = 6'd5;
  localparam op_t OP_RD_PAGE    = 6'd6;
  localparam op_t OP_LD_ROW     = 6'd7;
  localparam op_t OP_RD_RBELOW  = 6'd8;
  localparam op_t OP_RD_WRIGHT  = 6'd9;
  localparam op_t OP_RD_WBELOW  = 6'd10;
  localparam op_t OP_LD_W       = 6'd11;
  localparam op_t OP_LD_O       = 6'd12;
  localparam op_t OP_INC_PG     = 6'd13;
  localparam op_t OP_CLR_PG     = 6'd14;
  localparam op_t OP_RD_FH      = 6'd15;
  localparam op_t OP_TAKE       = 6'd16;
  localparam op_t OP_WR_SPLITW  = 6'd17;
  localparam op_t OP_WR_SPLITH  = 6'd18;
  localparam op_t OP_RD_PA      = 6'd19;
  localparam op_t OP_WR_PATCH   = 6'd20;
  localparam op_t OP_FIN_ALLOC  = 6'd21;
  localparam op_t OP_RD_HANDLE  = 6'd22;
  localparam op_t OP_CLR_USED   = 6'd23;
  localparam op_t OP_RD_O_RIGHT = 6'd24;
  localparam op_t OP_RD_O_LEFT  = 6'd25;
  localparam op_t OP_RD_O_BELOW = 6'd26;
  localparam op_t OP_RD_O_ABOVE = 6'd27;
  localparam op_t OP_MERGE_R    = 6'd28;
  localparam op_t OP_MERGE_L    = 6'd29;
  localparam op_t OP_MERGE_B    = 6'd30;
  localparam op_t OP_MERGE_U    = 6'd31;
  localparam op_t OP_WR_W       = 6'd32;

  typedef struct packed {
    op_t        op;
    logic [2:0] stat;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       size_bad;
    logic       handle_bad;
    logic       sc_last;
    logic       pg_last;
    logic       fh_nil;
    logic       out_free;
    logic       p1_hmatch;
    logic       w_fit1;
    logic       w_w_gt;
    logic       w_h_gt;
    logic       p2_fit;
    logic       w_used;
    logic       w_right_nil;
    logic       w_left_nil;
    logic       w_below_nil;
    logic       w_above_nil;
    logic       r_below_nil;
    logic       o_used;
    logic       o_right_nil;
    logic       o_below_nil;
    logic       rq_link_nil;
  } sts_t;

endpackage

@@ src/saa_dp.sv @@
// ----------------------------------------------------------------------------
// saa_dp - allocator datapath
// Node memory, working node registers, free chain head and result registers.
// ----------------------------------------------------------------------------
module saa_dp #(
  parameter int PAGES       = saa_pkg::PAGES_DEF,
  parameter int NODES       = saa_pkg::NODES_DEF,
  parameter int PAGE_WIDTH  = saa_pkg::PAGE_WIDTH_DEF,
  parameter int PAGE_HEIGHT = saa_pkg::PAGE_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  saa_pkg::req_t in_data,
  input  saa_pkg::cmd_t cmd,
  output saa_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output saa_pkg::res_t out_data
);
  import saa_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam int PW = $clog2(NODES + 1);
  localparam int XW = $clog2(PAGE_WIDTH);
  localparam int YW = $clog2(PAGE_HEIGHT);
  localparam int WW = $clog2(PAGE_WIDTH + 1);
  localparam int HW = $clog2(PAGE_HEIGHT + 1);
  localparam int GW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [PW-1:0] NIL     = PW'(NODES);
  localparam logic [PW-1:0] FH_INIT = (PAGES < NODES) ? PW'(PAGES) : PW'(NODES);

  typedef struct packed {
    logic [XW-1:0] col;
    logic [YW-1:0] row;
    logic [WW-1:0] width;
    logic [HW-1:0] height;
    logic [PW-1:0] right;
    logic [PW-1:0] left;
    logic [PW-1:0] below;
    logic [PW-1:0] above;
    logic          used;
    logic [GW-1:0] page;
    logic [PW-1:0] link;
  } node_t;

  node_t mem [NODES];
  node_t rd_q, w, o, r;
  logic [PW-1:0] wi, oi, ri, fh, pa, pv;
  logic          pk;  // patch field: 0 left, 1 above
  logic [GW-1:0] pg;
  logic [IW-1:0] sc;
  req_t          rq;
  res_t          res, out_q;
  logic          out_v;

  logic          re, we;
  logic [PW-1:0] ra, wa;
  node_t         wd;
  node_t         ml_rec, mu_rec;  // left / upper neighbor after absorbing w
  res_t          lat_res;

  function automatic node_t blank();
    node_t n;
    n       = '0;
    n.right = NIL;
    n.left  = NIL;
    n.below = NIL;
    n.above = NIL;
    n.link  = NIL;
    return n;
  endfunction

  always_comb begin
    node_t init_rec, sw_rec, sh_rec, pt_rec, tmp;
    init_rec = blank();
    if (32'(sc) < PAGES) begin
      init_rec.width  = WW'(PAGE_WIDTH);
      init_rec.height = HW'(PAGE_HEIGHT);
      init_rec.page   = GW'(sc);
    end
    if (32'(sc) >= PAGES && 32'(sc) < NODES - 1) init_rec.link = PW'(sc) + PW'(1);

    sw_rec        = blank();
    sw_rec.col    = XW'(32'(w.col) + 32'(rq.req_width));
    sw_rec.row    = w.row;
    sw_rec.width  = WW'(32'(w.width) - 32'(rq.req_width));
    sw_rec.height = w.height;
    sw_rec.page   = w.page;
    sw_rec.right  = w.right;
    sw_rec.left   = wi;

    sh_rec        = blank();
    sh_rec.col    = w.col;
    sh_rec.row    = YW'(32'(w.row) + 32'(rq.req_height));
    sh_rec.width  = w.width;
    sh_rec.height = HW'(32'(w.height) - 32'(rq.req_height));
    sh_rec.page   = w.page;
    sh_rec.below  = w.below;
    sh_rec.above  = wi;

    pt_rec = rd_q;
    if (pk) pt_rec.above = pv;
    else    pt_rec.left  = pv;

    ml_rec       = o;
    ml_rec.width = o.width + w.width;
    ml_rec.right = w.right;

    mu_rec        = o;
    mu_rec.height = o.height + w.height;
    mu_rec.below  = w.below;

    lat_res = '0;
    if (in_data.mode == MODE_FREE) lat_res.handle = in_data.free_handle;

    re = 1'b0;
    we = 1'b0;
    ra = wi;
    wa = wi;
    wd = w;
    tmp = w;
    case (cmd.op)
      OP_SWEEP:      begin we = 1'b1; wa = PW'(sc); wd = init_rec; end
      OP_RD_PAGE:    begin re = 1'b1; ra = PW'(pg); end
      OP_RD_RBELOW:  begin re = 1'b1; ra = r.below; end
      OP_RD_WRIGHT:  begin re = 1'b1; ra = w.right; end
      OP_RD_WBELOW:  begin re = 1'b1; ra = w.below; end
      OP_RD_FH:      begin re = 1'b1; ra = fh; end
      OP_RD_PA:      begin re = 1'b1; ra = pa; end
      OP_RD_HANDLE:  begin re = 1'b1; ra = PW'(rq.free_handle); end
      OP_RD_O_RIGHT: begin re = 1'b1; ra = w.right; end
      OP_RD_O_LEFT:  begin re = 1'b1; ra = w.left; end
      OP_RD_O_BELOW: begin re = 1'b1; ra = w.below; end
      OP_RD_O_ABOVE: begin re = 1'b1; ra = w.above; end
      OP_WR_SPLITW:  begin we = 1'b1; wa = oi; wd = sw_rec; end
      OP_WR_SPLITH:  begin we = 1'b1; wa = oi; wd = sh_rec; end
      OP_WR_PATCH:   begin we = 1'b1; wa = pa; wd = pt_rec; end
      OP_FIN_ALLOC:  begin we = 1'b1; tmp.used = 1'b1; wd = tmp; end
      OP_MERGE_R, OP_MERGE_B: begin
        we = 1'b1; wa = oi; tmp = o; tmp.link = fh; wd = tmp;
      end
      OP_MERGE_L, OP_MERGE_U: begin
        we = 1'b1; tmp.link = fh; wd = tmp;
      end
      OP_WR_W:       we = 1'b1;
      default:       ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa[IW-1:0]] <= wd;
    if (re) rd_q <= mem[ra[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sc    <= '0;
      fh    <= FH_INIT;
    end else begin
      out_v <= (out_v && !out_ready) || cmd.op == OP_PUSH;
      case (cmd.op)
        OP_LATCH: begin
          rq  <= in_data;
          pg  <= '0;
          res <= lat_res;
        end
        OP_SWEEP_INIT: begin sc <= '0; fh <= FH_INIT; end
        OP_SWEEP:      sc <= sc + IW'(1);
        OP_SET_STAT:   res.status <= cmd.stat;
        OP_PUSH:       out_q <= res;
        OP_RD_PAGE:    ri <= PW'(pg);
        OP_LD_ROW:     begin r <= rd_q; w <= rd_q; wi <= ri; end
        OP_RD_RBELOW:  ri <= r.below;
        OP_RD_WBELOW:  ri <= w.below;
        OP_RD_WRIGHT:  wi <= w.right;
        OP_LD_W:       w <= rd_q;
        OP_LD_O:       o <= rd_q;
        OP_INC_PG:     pg <= pg + GW'(1);
        OP_CLR_PG:     pg <= '0;
        OP_RD_FH:      oi <= fh;
        OP_TAKE:       fh <= rd_q.link;
        OP_WR_SPLITW: begin
          w.right <= oi;
          w.width <= WW'(rq.req_width);
          pa <= w.right; pv <= oi; pk <= 1'b0;
        end
        OP_WR_SPLITH: begin
          w.below  <= oi;
          w.height <= HW'(rq.req_height);
          pa <= w.below; pv <= oi; pk <= 1'b1;
        end
        OP_FIN_ALLOC: begin
          res.handle <= 12'(wi);
          res.page   <= 5'(w.page);
          res.col    <= 7'(w.col);
          res.row    <= 7'(w.row);
          res.status <= ST_OK;
        end
        OP_RD_HANDLE:  wi <= PW'(rq.free_handle);
        OP_CLR_USED:   w.used <= 1'b0;
        OP_RD_O_RIGHT: oi <= w.right;
        OP_RD_O_LEFT:  oi <= w.left;
        OP_RD_O_BELOW: oi <= w.below;
        OP_RD_O_ABOVE: oi <= w.above;
        OP_MERGE_R: begin
          w.width <= w.width + o.width;
          w.right <= o.right;
          fh <= oi;
          pa <= o.right; pv <= wi; pk <= 1'b0;
        end
        OP_MERGE_L: begin
          w  <= ml_rec;
          wi <= oi;
          fh <= wi;
          pa <= w.right; pv <= oi; pk <= 1'b0;
        end
        OP_MERGE_B: begin
          w.height <= w.height + o.height;
          w.below  <= o.below;
          fh <= oi;
          pa <= o.below; pv <= wi; pk <= 1'b1;
        end
        OP_MERGE_U: begin
          w  <= mu_rec;
          wi <= oi;
          fh <= wi;
          pa <= w.below; pv <= oi; pk <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.mode        = rq.mode;
    sts.size_bad    = rq.req_width == 8'd0 || rq.req_height == 8'd0 ||
                      32'(rq.req_width) > PAGE_WIDTH || 32'(rq.req_height) > PAGE_HEIGHT;
    sts.handle_bad  = 32'(rq.free_handle) >= NODES;
    sts.sc_last     = 32'(sc) == NODES - 1;
    sts.pg_last     = 32'(pg) == PAGES - 1;
    sts.fh_nil      = fh == NIL;
    sts.out_free    = !out_v || out_ready;
    sts.p1_hmatch   = 32'(r.height) == 32'(rq.req_height);
    sts.w_fit1      = !w.used && 32'(w.width) >= 32'(rq.req_width);
    sts.w_w_gt      = 32'(w.width) > 32'(rq.req_width);
    sts.w_h_gt      = 32'(w.height) > 32'(rq.req_height);
    sts.p2_fit      = 32'(w.height) >= 32'(rq.req_height) && w.right == NIL &&
                      !w.used && 32'(w.width) >= 32'(rq.req_width);
    sts.w_used      = w.used;
    sts.w_right_nil = w.right == NIL;
    sts.w_left_nil  = w.left == NIL;
    sts.w_below_nil = w.below == NIL;
    sts.w_above_nil = w.above == NIL;
    sts.r_below_nil = r.below == NIL;
    sts.o_used      = o.used;
    sts.o_right_nil = o.right == NIL;
    sts.o_below_nil = o.below == NIL;
    sts.rq_link_nil = rd_q.link == NIL;
  end

  assign out_valid = out_v;
  assign out_data  = out_q;

  a_fh_not_head: assert property (@(posedge clk) disable iff (rst)
    32'(fh) >= PAGES)
    else $error("free chain head points at a page head");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PUSH |-> (!out_v || out_ready))
    else $error("result pushed over an unconsumed result");

  a_take_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_TAKE |=> fh != oi)
    else $error("taken node still heads the free chain");

  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    we |-> wa != NIL)
    else $error("write to null node");

endmodule

@@ src/saa_ctrl.sv @@
// ----------------------------------------------------------------------------
// saa_ctrl - allocator sequencer
// Walks pages, rows and blocks, and steps splits, merges and pool sweeps.
// ----------------------------------------------------------------------------
module saa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  saa_pkg::sts_t sts,
  output saa_pkg::cmd_t cmd
);
  import saa_pkg::*;

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_DISP     = 6'd1;
  localparam logic [5:0] S_SWEEP    = 6'd2;
  localparam logic [5:0] S_P1_PAGE  = 6'd3;
  localparam logic [5:0] S_P1_ROW   = 6'd4;
  localparam logic [5:0] S_P1_BLK   = 6'd5;
  localparam logic [5:0] S_P1_BLKLD = 6'd6;
  localparam logic [5:0] S_SW_TAKE  = 6'd7;
  localparam logic [5:0] S_SW_WR    = 6'd8;
  localparam logic [5:0] S_FIN      = 6'd9;
  localparam logic [5:0] S_P2_PAGE  = 6'd10;
  localparam logic [5:0] S_P2_ROW   = 6'd11;
  localparam logic [5:0] S_P2_CHK   = 6'd12;
  localparam logic [5:0] S_P2_CNT   = 6'd13;
  localparam logic [5:0] S_HS_TAKE  = 6'd14;
  localparam logic [5:0] S_HS_WR    = 6'd15;
  localparam logic [5:0] S_HS_AFTER = 6'd16;
  localparam logic [5:0] S_PT_RD    = 6'd17;
  localparam logic [5:0] S_PT_WR    = 6'd18;
  localparam logic [5:0] S_F_LD     = 6'd19;
  localparam logic [5:0] S_F_CHK    = 6'd20;
  localparam logic [5:0] S_F_R      = 6'd21;
  localparam logic [5:0] S_F_R2     = 6'd22;
  localparam logic [5:0] S_F_R3     = 6'd23;
  localparam logic [5:0] S_F_L      = 6'd24;
  localparam logic [5:0] S_F_L2     = 6'd25;
  localparam logic [5:0] S_F_L3     = 6'd26;
  localparam logic [5:0] S_F_V      = 6'd27;
  localparam logic [5:0] S_F_B2     = 6'd28;
  localparam logic [5:0] S_F_B3     = 6'd29;
  localparam logic [5:0] S_F_U      = 6'd30;
  localparam logic [5:0] S_F_U2     = 6'd31;
  localparam logic [5:0] S_F_U3     = 6'd32;
  localparam logic [5:0] S_F_END    = 6'd33;
  localparam logic [5:0] S_DONE     = 6'd34;

  logic [5:0] state, state_next, ret, ret_next;
  logic       flushing, flushing_next;

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    flushing_next = flushing;
    cmd.op        = OP_NOP;
    cmd.stat      = ST_OK;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LATCH; state_next = S_DISP;
      end
      S_DISP: begin
        case (sts.mode)
          MODE_ALLOC: begin
            if (sts.size_bad) begin
              cmd.op = OP_SET_STAT; cmd.stat = ST_BAD_SIZE; state_next = S_DONE;
            end else begin
              state_next = S_P1_PAGE;
            end
          end
          MODE_FREE: begin
            if (sts.handle_bad) begin
              cmd.op = OP_SET_STAT; cmd.stat = ST_BAD_HANDLE; state_next = S_DONE;
            end else begin
              cmd.op = OP_RD_HANDLE; state_next = S_F_LD;
            end
          end
          MODE_FLUSH: begin
            cmd.op = OP_SWEEP_INIT; flushing_next = 1'b1; state_next = S_SWEEP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (sts.sc_last) begin
          state_next    = flushing ? S_DONE : S_IDLE;
          flushing_next = 1'b0;
        end
      end
      S_P1_PAGE: begin cmd.op = OP_RD_PAGE; state_next = S_P1_ROW; end
      S_P1_ROW:  begin cmd.op = OP_LD_ROW;  state_next = S_P1_BLK; end
      S_P1_BLK: begin
        if (!sts.p1_hmatch || (!sts.w_fit1 && sts.w_right_nil)) begin
          if (!sts.r_below_nil) begin
            cmd.op = OP_RD_RBELOW; state_next = S_P1_ROW;
          end else if (sts.pg_last) begin
            cmd.op = OP_CLR_PG; state_next = S_P2_PAGE;
          end else begin
            cmd.op = OP_INC_PG; state_next = S_P1_PAGE;
          end
        end else if (sts.w_fit1) begin
          if (!sts.w_w_gt) begin
            cmd.op = OP_FIN_ALLOC; state_next = S_DONE;
          end else if (sts.fh_nil) begin
            cmd.op = OP_SET_STAT; cmd.stat = ST_POOL_EMPTY; state_next = S_DONE;
          end else begin
            cmd.op = OP_RD_FH; state_next = S_SW_TAKE;
          end
        end else begin
          cmd.op = OP_RD_WRIGHT; state_next = S_P1_BLKLD;
        end
      end
      S_P1_BLKLD: begin cmd.op = OP_LD_W; state_next = S_P1_BLK; end
      S_SW_TAKE:  begin cmd.op = OP_TAKE; state_next = S_SW_WR; end
      S_SW_WR: begin
        cmd.op = OP_WR_SPLITW;
        if (sts.w_right_nil) begin
          state_next = S_FIN;
        end else begin
          ret_next = S_FIN; state_next = S_PT_RD;
        end
      end
      S_FIN:     begin cmd.op = OP_FIN_ALLOC; state_next = S_DONE; end
      S_P2_PAGE: begin cmd.op = OP_RD_PAGE; state_next = S_P2_ROW; end
      S_P2_ROW:  begin cmd.op = OP_LD_ROW;  state_next = S_P2_CHK; end
      S_P2_CHK: begin
        if (!sts.p2_fit) begin
          if (!sts.w_below_nil) begin
            cmd.op = OP_RD_WBELOW; state_next = S_P2_ROW;
          end else if (sts.pg_last) begin
            cmd.op = OP_SET_STAT; cmd.stat = ST_NO_SPACE; state_next = S_DONE;
          end else begin
            cmd.op = OP_INC_PG; state_next = S_P2_PAGE;
          end
        end else if (!sts.w_h_gt && !sts.w_w_gt) begin
          cmd.op = OP_FIN_ALLOC; state_next = S_DONE;
        end else if (sts.fh_nil) begin
          cmd.op = OP_SET_STAT; cmd.stat = ST_POOL_EMPTY; state_next = S_DONE;
        end else begin
          cmd.op = OP_RD_FH;
          if (sts.w_h_gt && sts.w_w_gt) state_next = S_P2_CNT;
          else if (sts.w_h_gt)          state_next = S_HS_TAKE;
          else                          state_next = S_SW_TAKE;
        end
      end
      S_P2_CNT: begin
        if (sts.rq_link_nil) begin
          cmd.op = OP_SET_STAT; cmd.stat = ST_POOL_EMPTY; state_next = S_DONE;
        end else begin
          cmd.op = OP_TAKE; state_next = S_HS_WR;
        end
      end
      S_HS_TAKE: begin cmd.op = OP_TAKE; state_next = S_HS_WR; end
      S_HS_WR: begin
        cmd.op = OP_WR_SPLITH;
        if (sts.w_below_nil) begin
          state_next = S_HS_AFTER;
        end else begin
          ret_next = S_HS_AFTER; state_next = S_PT_RD;
        end
      end
      S_HS_AFTER: begin
        if (sts.w_w_gt) begin
          cmd.op = OP_RD_FH; state_next = S_SW_TAKE;
        end else begin
          cmd.op = OP_FIN_ALLOC; state_next = S_DONE;
        end
      end
      S_PT_RD: begin cmd.op = OP_RD_PA;    state_next = S_PT_WR; end
      S_PT_WR: begin cmd.op = OP_WR_PATCH; state_next = ret; end
      S_F_LD:  begin cmd.op = OP_LD_W;     state_next = S_F_CHK; end
      S_F_CHK: begin
        if (!sts.w_used) begin
          cmd.op = OP_SET_STAT; cmd.stat = ST_BAD_HANDLE; state_next = S_DONE;
        end else begin
          cmd.op = OP_CLR_USED; state_next = S_F_R;
        end
      end
      S_F_R: begin
        if (sts.w_right_nil) begin
          state_next = S_F_L;
        end else begin
          cmd.op = OP_RD_O_RIGHT; state_next = S_F_R2;
        end
      end
      S_F_R2: begin cmd.op = OP_LD_O; state_next = S_F_R3; end
      S_F_R3: begin
        if (sts.o_used) begin
          state_next = S_F_L;
        end else begin
          cmd.op = OP_MERGE_R;
          if (sts.o_right_nil) state_next = S_F_L;
          else begin ret_next = S_F_L; state_next = S_PT_RD; end
        end
      end
      S_F_L: begin
        if (sts.w_left_nil) begin
          state_next = S_F_V;
        end else begin
          cmd.op = OP_RD_O_LEFT; state_next = S_F_L2;
        end
      end
      S_F_L2: begin cmd.op = OP_LD_O; state_next = S_F_L3; end
      S_F_L3: begin
        if (sts.o_used) begin
          state_next = S_F_V;
        end else begin
          cmd.op = OP_MERGE_L;
          if (sts.w_right_nil) state_next = S_F_V;
          else begin ret_next = S_F_V; state_next = S_PT_RD; end
        end
      end
      S_F_V: begin
        if (!sts.w_left_nil || !sts.w_right_nil) begin
          state_next = S_F_END;
        end else if (sts.w_below_nil) begin
          state_next = S_F_U;
        end else begin
          cmd.op = OP_RD_O_BELOW; state_next = S_F_B2;
        end
      end
      S_F_B2: begin cmd.op = OP_LD_O; state_next = S_F_B3; end
      S_F_B3: begin
        if (!sts.o_right_nil || sts.o_used) begin
          state_next = S_F_U;
        end else begin
          cmd.op = OP_MERGE_B;
          if (sts.o_below_nil) state_next = S_F_U;
          else begin ret_next = S_F_U; state_next = S_PT_RD; end
        end
      end
      S_F_U: begin
        if (sts.w_above_nil) begin
          state_next = S_F_END;
        end else begin
          cmd.op = OP_RD_O_ABOVE; state_next = S_F_U2;
        end
      end
      S_F_U2: begin cmd.op = OP_LD_O; state_next = S_F_U3; end
      S_F_U3: begin
        if (!sts.o_right_nil || sts.o_used) begin
          state_next = S_F_END;
        end else begin
          cmd.op = OP_MERGE_U;
          if (sts.w_below_nil) state_next = S_F_END;
          else begin ret_next = S_F_END; state_next = S_PT_RD; end
        end
      end
      S_F_END: begin cmd.op = OP_WR_W; state_next = S_DONE; end
      S_DONE: if (sts.out_free) begin
        cmd.op = OP_PUSH; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SWEEP;
      ret      <= S_IDLE;
      flushing <= 1'b0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      flushing <= flushing_next;
    end
  end

  assign in_ready = state == S_IDLE;

endmodule

@@ src/shelf_atlas_allocator_top.sv @@
// ----------------------------------------------------------------------------
// shelf_atlas_allocator_top - shelf-packing texture atlas allocator
// Allocates, frees and flushes rectangles over a set of equal atlas pages.
// ----------------------------------------------------------------------------
// One request at a time. After reset (and for every flush request) the block
// sweeps the node memory one entry per cycle with in_ready low; a flush
// answers when its sweep is done. An allocate walks rows and their blocks
// in the first pass over all pages and, if that finds nothing, walks rows
// again in the second pass, then does any splits. The pace is set by the
// single-port node memory: every list step is one registered read. A finished
// result sits in the output register and the next request is taken meanwhile.
module shelf_atlas_allocator_top #(
  parameter int PAGES       = saa_pkg::PAGES_DEF,
  parameter int NODES       = saa_pkg::NODES_DEF,
  parameter int PAGE_WIDTH  = saa_pkg::PAGE_WIDTH_DEF,
  parameter int PAGE_HEIGHT = saa_pkg::PAGE_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  saa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output saa_pkg::res_t out_data
);
  import saa_pkg::*;

  cmd_t cmd;   // sequencer command to the datapath
  sts_t sts;   // datapath flags back to the sequencer

  saa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  saa_dp #(
    .PAGES       (PAGES),
    .NODES       (NODES),
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
